/* sv/small_set_table_core_macros.svh */
// Assertion macros shared by the small set table core.
`ifndef SMALL_SET_TABLE_CORE_MACROS_SVH
`define SMALL_SET_TABLE_CORE_MACROS_SVH

// Clocked check on clk_i, held off while rst_ni is low.
`define SST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication form: whenever cond holds, chk must hold in the same cycle.
`define SST_ASSERT_IMPL(lbl, cond, chk, msg) \
  `SST_ASSERT(lbl, (cond) |-> (chk), msg)

// Next-cycle form: whenever cond holds, chk must hold in the next cycle.
`define SST_ASSERT_NEXT(lbl, cond, chk, msg) \
  `SST_ASSERT(lbl, (cond) |=> (chk), msg)

`endif

/* sv/sst_pkg.sv */
// Types, constants and codes for the small set table core.
package sst_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned FILL_W       = 5;

  // Request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_QUERY  = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_PRESENT = 2'd1,
    STAT_ABSENT  = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_e;

  // Sequencer to datapath controls
  typedef struct packed {
    logic latch;      // capture request, clear index and hit
    logic mem_rd;     // read table into the data register
    logic rd_next;    // read at index + 1 instead of index
    logic idx_inc;    // advance the index
    logic hit_set;    // record a match
    logic mem_wr;     // write the table
    logic wr_append;  // write the request value at the fill count
    logic cnt_inc;    // grow the fill count
    logic cnt_dec;    // shrink the fill count
    logic res_load;   // capture found and status
  } ctrl_t;

  // Datapath to sequencer status
  typedef struct packed {
    logic is_insert;
    logic is_remove;
    logic eq;          // compare unit: data register matches request value
    logic hit;
    logic empty;
    logic full;
    logic scan_last;   // index + 1 equals fill count
    logic shift_last;  // index + 2 equals fill count
  } stat_t;

endpackage

/* sv/sst_dp.sv */
// Datapath: entry table, shared compare unit, index and fill count registers.
module sst_dp #(
  parameter int unsigned CAPACITY = sst_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [sst_pkg::OP_W-1:0]            operation_i,
  input  logic signed [sst_pkg::VALUE_W-1:0]  value_i,
  input  sst_pkg::ctrl_t                      ctrl_i,
  output sst_pkg::stat_t                      stat_o,
  output logic                                found_o,
  output logic [sst_pkg::STAT_W-1:0]          status_o,
  output logic [sst_pkg::FILL_W-1:0]          fill_count_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [sst_pkg::OP_W-1:0]    op_q;
  logic [sst_pkg::VALUE_W-1:0] value_q;
  logic [IDX_W-1:0]            idx_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        hit_q;
  logic [sst_pkg::VALUE_W-1:0] rdata_q;
  logic                        found_q;
  logic [sst_pkg::STAT_W-1:0]  status_q;
  logic [sst_pkg::STAT_W-1:0]  status_d;

  logic [sst_pkg::VALUE_W-1:0] mem [CAPACITY];

  logic [CNT_W-1:0]            idx_ext;
  logic [CNT_W-1:0]            idx_p1;
  logic [CNT_W-1:0]            idx_p2;
  logic [IDX_W-1:0]            rd_addr;
  logic [IDX_W-1:0]            wr_addr;
  logic [sst_pkg::VALUE_W-1:0] wr_data;
  logic [CNT_W+sst_pkg::FILL_W-1:0] cnt_wide;

  // Index arithmetic
  assign idx_ext = CNT_W'(idx_q);
  assign idx_p1  = idx_ext + CNT_W'(1);
  assign idx_p2  = idx_ext + CNT_W'(2);

  // Table ports
  assign rd_addr = ctrl_i.rd_next ? IDX_W'(idx_p1) : idx_q;
  assign wr_addr = ctrl_i.wr_append ? cnt_q[IDX_W-1:0] : idx_q;
  assign wr_data = ctrl_i.wr_append ? value_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mem_rd) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      op_q    <= operation_i;
      value_q <= value_i;
    end
  end

  // Index, hit flag and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      hit_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (ctrl_i.latch) begin
        idx_q <= '0;
        hit_q <= 1'b0;
      end else begin
        if (ctrl_i.idx_inc) idx_q <= IDX_W'(idx_p1);
        if (ctrl_i.hit_set) hit_q <= 1'b1;
      end
      if (ctrl_i.cnt_inc) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (ctrl_i.cnt_dec) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Result status from operation, hit and fullness
  always_comb begin
    case (op_q)
      sst_pkg::OP_INSERT: begin
        if (hit_q) begin
          status_d = sst_pkg::STAT_PRESENT;
        end else if (stat_o.full) begin
          status_d = sst_pkg::STAT_FULL;
        end else begin
          status_d = sst_pkg::STAT_DONE;
        end
      end
      sst_pkg::OP_REMOVE: begin
        status_d = hit_q ? sst_pkg::STAT_DONE : sst_pkg::STAT_ABSENT;
      end
      default: begin
        status_d = sst_pkg::STAT_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= 1'b0;
      status_q <= sst_pkg::STAT_DONE;
    end else if (ctrl_i.res_load) begin
      found_q  <= hit_q;
      status_q <= status_d;
    end
  end

  // Status toward the sequencer; eq is the shared compare unit
  assign stat_o.is_insert  = (op_q == sst_pkg::OP_INSERT);
  assign stat_o.is_remove  = (op_q == sst_pkg::OP_REMOVE);
  assign stat_o.eq         = (rdata_q == value_q);
  assign stat_o.hit        = hit_q;
  assign stat_o.empty      = (cnt_q == '0);
  assign stat_o.full       = (cnt_q == CNT_W'(CAPACITY));
  assign stat_o.scan_last  = (idx_p1 == cnt_q);
  assign stat_o.shift_last = (idx_p2 == cnt_q);

  // Result ports
  assign cnt_wide     = {{sst_pkg::FILL_W{1'b0}}, cnt_q};
  assign found_o      = found_q;
  assign status_o     = status_q;
  assign fill_count_o = cnt_wide[sst_pkg::FILL_W-1:0];

endmodule

/* sv/sst_ctrl.sv */
// Sequencer: steps the scan, the decision and the shift-down of the table.
module sst_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  sst_pkg::stat_t  stat_i,
  output sst_pkg::ctrl_t  ctrl_o,
  output logic            busy_o,
  output logic            done_o
);

  sst_pkg::state_e state_q, state_d;
  logic            done_q, done_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sst_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = stat_i.empty ? sst_pkg::S_DECIDE : sst_pkg::S_SCAN_RD;
        end
      end
      sst_pkg::S_SCAN_RD: begin
        state_d = sst_pkg::S_SCAN_CMP;
      end
      sst_pkg::S_SCAN_CMP: begin
        if (stat_i.eq || stat_i.scan_last) begin
          state_d = sst_pkg::S_DECIDE;
        end else begin
          state_d = sst_pkg::S_SCAN_RD;
        end
      end
      sst_pkg::S_DECIDE: begin
        if (stat_i.is_remove && stat_i.hit && !stat_i.scan_last) begin
          state_d = sst_pkg::S_SHIFT_RD;
        end else begin
          state_d = sst_pkg::S_IDLE;
        end
      end
      sst_pkg::S_SHIFT_RD: begin
        state_d = sst_pkg::S_SHIFT_WR;
      end
      sst_pkg::S_SHIFT_WR: begin
        state_d = stat_i.shift_last ? sst_pkg::S_IDLE : sst_pkg::S_SHIFT_RD;
      end
      default: begin
        state_d = sst_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o = '0;
    done_d = 1'b0;
    case (state_q)
      sst_pkg::S_IDLE: begin
        ctrl_o.latch = start_i;
      end
      sst_pkg::S_SCAN_RD: begin
        ctrl_o.mem_rd = 1'b1;
      end
      sst_pkg::S_SCAN_CMP: begin
        if (stat_i.eq) begin
          ctrl_o.hit_set = 1'b1;
        end else if (!stat_i.scan_last) begin
          ctrl_o.idx_inc = 1'b1;
        end
      end
      sst_pkg::S_DECIDE: begin
        ctrl_o.res_load = 1'b1;
        if (stat_i.is_insert && !stat_i.hit && !stat_i.full) begin
          ctrl_o.mem_wr    = 1'b1;
          ctrl_o.wr_append = 1'b1;
          ctrl_o.cnt_inc   = 1'b1;
          done_d           = 1'b1;
        end else if (stat_i.is_remove && stat_i.hit) begin
          // last entry removed: nothing to shift
          if (stat_i.scan_last) begin
            ctrl_o.cnt_dec = 1'b1;
            done_d         = 1'b1;
          end
        end else begin
          done_d = 1'b1;
        end
      end
      sst_pkg::S_SHIFT_RD: begin
        ctrl_o.mem_rd  = 1'b1;
        ctrl_o.rd_next = 1'b1;
      end
      sst_pkg::S_SHIFT_WR: begin
        ctrl_o.mem_wr  = 1'b1;
        ctrl_o.idx_inc = 1'b1;
        if (stat_i.shift_last) begin
          ctrl_o.cnt_dec = 1'b1;
          done_d         = 1'b1;
        end
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sst_pkg::S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != sst_pkg::S_IDLE);
  assign done_o = done_q;

endmodule

/* sv/small_set_table_core.sv */
// Top level of the small set table core: sequencer plus datapath.
//
// Keeps an unordered, packed set of up to CAPACITY distinct 32-bit values.
// A request (query, insert, remove) is taken when start_i is high and busy_o
// is low; its single result shows on found_o, status_o and fill_count_o for
// exactly one cycle with done_o high and must be taken then. One table port
// and one equality comparator do all the work: the scan reads and then
// compares each entry examined, and a removal then reads and writes back
// each entry moved down. The scan stops at the match and only the entries
// after it are moved.
// busy_o drops as done_o rises, so the next request may start in that cycle.
// The table needs no clearing after reset; of its contents only the fill count is reset.
`include "small_set_table_core_macros.svh"

module small_set_table_core #(
  parameter int unsigned CAPACITY = sst_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [sst_pkg::OP_W-1:0]            operation_i,
  input  logic signed [sst_pkg::VALUE_W-1:0]  value_i,
  output logic                                done_o,
  output logic                                found_o,
  output logic [sst_pkg::STAT_W-1:0]          status_o,
  output logic [sst_pkg::FILL_W-1:0]          fill_count_o
);

  sst_pkg::ctrl_t ctrl;
  sst_pkg::stat_t stat;
  logic           res_flagged;  // result strobe with a status other than done
  logic           found_match;  // found flag agrees with a present status

  // Sequencer
  sst_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Table and compare datapath
  sst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .found_o      (found_o),
    .status_o     (status_o),
    .fill_count_o (fill_count_o)
  );

  // Checks
  assign res_flagged = done_o && (status_o != sst_pkg::STAT_DONE);
  assign found_match = (found_o == (status_o == sst_pkg::STAT_PRESENT));

  `SST_ASSERT_IMPL(a_done_idle, done_o, !busy_o, "result strobe while sequencer busy")
  `SST_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o, "accepted request did not go busy")
  `SST_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "result strobe longer than one cycle")
  `SST_ASSERT_IMPL(a_found_status, res_flagged, found_match, "found flag disagrees with status")

endmodule
